FILE: src/xdwd_pkg.sv
// Shared types and constants of the XOR delta word-array decoder.
// No dependencies; imported by the parser and the top level.
package xdwd_pkg;

  // Size of the word store and its address width
  localparam int MAX_WORDS = 136;
  localparam int WORD_AW   = $clog2(MAX_WORDS);

  // Configuration port
  localparam int CFG_IW = 4;
  localparam int CFG_DW = 8;
  localparam logic [CFG_IW-1:0] CFG_BYTE_MODE  = CFG_IW'(0);
  localparam logic [CFG_IW-1:0] CFG_WORD_COUNT = CFG_IW'(1);
  localparam logic [7:0]        WORD_COUNT_RST = 8'd128;

  // Stream codes
  localparam logic [7:0] CMD_END = 8'd255;

  // What a transfer asks of the store and the result stage
  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_LOAD,
    KIND_XOR,
    KIND_END,
    KIND_BAD
  } op_kind_t;

  typedef struct packed {
    op_kind_t    kind;
    logic [7:0]  index;
    logic [31:0] data;
  } op_t;

endpackage

FILE: src/xdwd_if.sv
// Channel interfaces of the XOR delta word-array decoder.
// Request channel carries stream bytes and loads; response channel carries results.
interface xdwd_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [7:0]  data_byte;
  logic [7:0]  load_index;
  logic [31:0] load_value;

  modport source (output valid, req_type, data_byte, load_index, load_value, input ready);
  modport sink   (input valid, req_type, data_byte, load_index, load_value, output ready);
endinterface

interface xdwd_rsp_if;
  logic        valid;
  logic        ready;
  logic [7:0]  word_index;
  logic [31:0] word_value;
  logic        record_end;
  logic        bad_index;

  modport source (output valid, word_index, word_value, record_end, bad_index, input ready);
  modport sink   (input valid, word_index, word_value, record_end, bad_index, output ready);
endinterface

FILE: src/xdwd_parse.sv
// Stream parser: walks command, mask and chunk bytes and issues at most one operation per transfer.
// Depends on xdwd_pkg for op_t and the store size.
module xdwd_parse (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  logic            req_type,
  input  logic [7:0]      data_byte,
  input  logic [7:0]      load_index,
  input  logic [31:0]     load_value,
  input  logic            byte_mode,
  input  logic [8:0]      bound,
  output xdwd_pkg::op_t   op
);
  import xdwd_pkg::*;

  localparam logic [1:0] PH_CMD   = 2'd0;
  localparam logic [1:0] PH_MASK  = 2'd1;
  localparam logic [1:0] PH_CHUNK = 2'd2;

  logic [1:0]  phase, phase_next;
  logic [7:0]  cur, cur_next;
  logic [8:0]  mask, mask_next;
  logic [23:0] chunk, chunk_next;
  logic [1:0]  count, count_next;
  logic        done;
  logic [31:0] x;
  logic [7:0]  rest;
  logic [2:0]  pos;
  logic [3:0]  step;

  // Lowest selected word after the current one
  always_comb begin
    rest = mask[8:1];
    pos  = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (rest[i]) pos = 3'(i);
    end
    step = {1'b0, pos} + 4'd1;
  end

  // Decode one transfer against the parse state
  always_comb begin
    phase_next = phase;
    cur_next   = cur;
    mask_next  = mask;
    chunk_next = chunk;
    count_next = count;
    done       = 1'b0;
    x          = 32'd0;
    op         = '{kind: KIND_NONE, index: 8'd0, data: 32'd0};
    if (req_type) begin
      if ({1'b0, load_index} < 9'(MAX_WORDS)) begin
        op = '{kind: KIND_LOAD, index: load_index, data: load_value};
      end
    end else begin
      case (phase)
        PH_MASK: begin
          mask_next  = {data_byte, 1'b1};
          phase_next = PH_CHUNK;
        end
        PH_CHUNK: begin
          if ({1'b0, cur} >= bound) begin
            op         = '{kind: KIND_BAD, index: cur, data: 32'd0};
            phase_next = PH_CMD;
            mask_next  = 9'd0;
            chunk_next = 24'd0;
            count_next = 2'd0;
          end else begin
            if (byte_mode) begin
              x          = {24'd0, data_byte};
              done       = 1'b1;
              chunk_next = 24'd0;
              count_next = 2'd0;
            end else if (count == 2'd3) begin
              x          = {data_byte, chunk};
              done       = 1'b1;
              chunk_next = 24'd0;
              count_next = 2'd0;
            end else begin
              case (count)
                2'd0:    chunk_next[7:0]   = data_byte;
                2'd1:    chunk_next[15:8]  = data_byte;
                default: chunk_next[23:16] = data_byte;
              endcase
              count_next = count + 2'd1;
            end
            // Apply the chunk and skip to the next selected word
            if (done) begin
              op = '{kind: KIND_XOR, index: cur, data: x};
              if (rest == 8'd0) begin
                mask_next  = 9'd0;
                cur_next   = cur + 8'd1;
                phase_next = PH_CMD;
              end else begin
                mask_next = mask >> step;
                cur_next  = cur + {4'd0, step};
              end
            end
          end
        end
        default: begin
          phase_next = PH_CMD;
          if (data_byte == CMD_END) begin
            op = '{kind: KIND_END, index: 8'd0, data: 32'd0};
          end else begin
            cur_next   = {1'b0, data_byte[6:0]};
            chunk_next = 24'd0;
            count_next = 2'd0;
            if (data_byte[7]) begin
              phase_next = PH_MASK;
            end else begin
              mask_next  = 9'd1;
              phase_next = PH_CHUNK;
            end
          end
        end
      endcase
    end
  end

  // Advance the parse state on each transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_CMD;
      cur   <= 8'd0;
      mask  <= 9'd0;
      chunk <= 24'd0;
      count <= 2'd0;
    end else if (accept) begin
      phase <= phase_next;
      cur   <= cur_next;
      mask  <= mask_next;
      chunk <= chunk_next;
      count <= count_next;
    end
  end

endmodule

FILE: src/xor_delta_word_array_decoder.sv
// XOR delta word-array decoder. Takes one request per cycle while the execute stage is
// not held: a stream byte or a direct word load. The parser decodes the byte in the
// cycle it is taken and reads the word store; the execute stage then XORs the chunk into
// the word, writes it back and loads the result register. The store has one write and
// one read port; a read of a word in the same cycle as a write to it is forwarded.
// Reset clears per-word valid bits at once, so no clearing pass is needed. Requests keep
// flowing while a result waits, until the execute stage is held by a full result register.
// Depends on xdwd_pkg, xdwd_if and xdwd_parse.
module xor_delta_word_array_decoder (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [xdwd_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [xdwd_pkg::CFG_DW-1:0]  cfg_data,
  xdwd_req_if.sink                     req,
  xdwd_rsp_if.source                   rsp
);
  import xdwd_pkg::*;

  logic        byte_mode;
  logic [7:0]  word_count;
  logic [8:0]  bound;
  logic        accept;
  op_t         op;
  logic [WORD_AW-1:0] rd_addr;

  logic        s1_valid;
  op_t         s1_op;
  logic        s1_has_result;
  logic        s1_advance;
  logic        s1_wr;
  logic [31:0] s1_old, s1_new, wr_data;

  logic [31:0]          word_mem [MAX_WORDS];
  logic [MAX_WORDS-1:0] word_vld;
  logic [31:0]          rd_word;
  logic                 rd_vld;
  logic                 fwd_hit;
  logic [31:0]          fwd_data;

  logic        out_valid;
  logic        out_take;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_mode  <= 1'b0;
      word_count <= WORD_COUNT_RST;
    end else if (cfg_write) begin
      if (cfg_index == CFG_BYTE_MODE)  byte_mode  <= cfg_data[0];
      if (cfg_index == CFG_WORD_COUNT) word_count <= cfg_data[7:0];
    end
  end

  assign bound = ({1'b0, word_count} < 9'(MAX_WORDS)) ? {1'b0, word_count} : 9'(MAX_WORDS);

  // Handshake and stage flow
  assign out_take      = !out_valid || rsp.ready;
  assign s1_has_result = (s1_op.kind == KIND_XOR) || (s1_op.kind == KIND_END) ||
                         (s1_op.kind == KIND_BAD);
  assign s1_advance    = s1_valid && (!s1_has_result || out_take);
  assign req.ready     = !s1_valid || s1_advance;
  assign accept        = req.valid && req.ready;

  xdwd_parse u_parse (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .req_type   (req.req_type),
    .data_byte  (req.data_byte),
    .load_index (req.load_index),
    .load_value (req.load_value),
    .byte_mode  (byte_mode),
    .bound      (bound),
    .op         (op)
  );

  assign rd_addr = (op.kind == KIND_XOR) ? op.index[WORD_AW-1:0] : '0;

  // Execute stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= (op.kind != KIND_NONE);
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op <= op;
    end
  end

  assign s1_old  = fwd_hit ? fwd_data : (rd_vld ? rd_word : 32'd0);
  assign s1_new  = s1_old ^ s1_op.data;
  assign s1_wr   = s1_advance && ((s1_op.kind == KIND_XOR) || (s1_op.kind == KIND_LOAD));
  assign wr_data = (s1_op.kind == KIND_LOAD) ? s1_op.data : s1_new;

  // Word store: one write, one registered read, forward a same-cycle write
  always_ff @(posedge clk) begin
    if (s1_wr) begin
      word_mem[s1_op.index[WORD_AW-1:0]] <= wr_data;
    end
    if (accept) begin
      rd_word  <= word_mem[rd_addr];
      fwd_data <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_vld <= '0;
      rd_vld   <= 1'b0;
      fwd_hit  <= 1'b0;
    end else begin
      if (s1_wr) begin
        word_vld[s1_op.index[WORD_AW-1:0]] <= 1'b1;
      end
      if (accept) begin
        rd_vld  <= word_vld[rd_addr];
        fwd_hit <= s1_wr && (s1_op.index[WORD_AW-1:0] == rd_addr);
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance && s1_has_result) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && s1_has_result) begin
      rsp.word_index <= s1_op.index;
      rsp.word_value <= (s1_op.kind == KIND_XOR) ? s1_new : 32'd0;
      rsp.record_end <= (s1_op.kind == KIND_END);
      rsp.bad_index  <= (s1_op.kind == KIND_BAD);
    end
  end

  assign rsp.valid = out_valid;

  // Checks
  a_end_bad_excl: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !(rsp.record_end && rsp.bad_index))
    else $error("record end and bad index in one result");

  a_end_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.record_end) |-> (rsp.word_index == 8'd0 && rsp.word_value == 32'd0))
    else $error("record end result carries data");

  a_bad_bound: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.bad_index) |-> ({1'b0, rsp.word_index} >= bound))
    else $error("bad index result below the bound");

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_advance) |-> !req.ready)
    else $error("request taken while execute stage is held");

  a_store_range: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && (s1_op.kind == KIND_XOR || s1_op.kind == KIND_LOAD)) |->
      ({1'b0, s1_op.index} < 9'(MAX_WORDS)))
    else $error("store access out of range");

endmodule
